// ----- hdl/adpcm_channel_decoder_core_macros.svh -----
// Assertion macros used by the checker file of the ADPCM channel decoder.
// No dependencies; include by bare file name.
`ifndef ADPCM_CHANNEL_DECODER_CORE_MACROS_SVH
`define ADPCM_CHANNEL_DECODER_CORE_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define ACD_ASSERT(label, clk_sig, rstn_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) prop) \
    else $error(msg);

// Same, using the clk and rst_n names in scope.
`define ACD_ASSERT_DEF(label, prop, msg) \
  `ACD_ASSERT(label, clk, rst_n, prop, msg)

`endif

// ----- hdl/acd_pkg.sv -----
// Shared types, codes and the step-size table of the ADPCM channel decoder.
// No dependencies.
package acd_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 22;

  localparam logic [CFG_IDX_W-1:0] REG_LOOP_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT      = 2'd2;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam int OFFSET_W = 25;

  localparam logic signed [15:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [15:0] SAMPLE_MIN = -16'sh7fff;
  localparam logic [6:0]         INDEX_MAX  = 7'd88;

  typedef struct packed {
    logic        opcode;
    logic [31:0] data_word;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0]    sample_out;
    logic [OFFSET_W-1:0]   byte_offset_out;
    logic                  high_nibble_next;
    logic                  playing;
  } out_item_t;

  // Working context of the channel, one memory word.
  typedef struct packed {
    logic                active;
    logic [OFFSET_W-1:0] byte_offset;
    logic                second_nibble;
    logic [6:0]          step_index;
    logic signed [15:0]  sample_value;
  } ctx_t;

  // Values captured at the loop start.
  typedef struct packed {
    logic [6:0]         loop_index;
    logic signed [15:0] loop_sample;
  } snap_t;

  typedef struct packed {
    logic [OFFSET_W-1:0] start_off;
    logic [OFFSET_W-1:0] end_off;
    logic                repeat_loop;
  } loop_cfg_t;

  localparam int CTX_W  = $bits(ctx_t);
  localparam int SNAP_W = $bits(snap_t);

  localparam int CTX_DEPTH = 2;
  localparam int RAM_AW    = 1;
  localparam logic [RAM_AW-1:0] ADDR_CTX  = 1'b0;
  localparam logic [RAM_AW-1:0] ADDR_SNAP = 1'b1;

  localparam int OFIFO_DEPTH = 4;
  localparam int OFIFO_AW    = 2;

  function automatic logic [14:0] step_size(input logic [6:0] idx);
    logic [14:0] t;
    case (idx)
      7'd0: t = 15'd7;        7'd1: t = 15'd8;        7'd2: t = 15'd9;
      7'd3: t = 15'd10;       7'd4: t = 15'd11;       7'd5: t = 15'd12;
      7'd6: t = 15'd13;       7'd7: t = 15'd14;       7'd8: t = 15'd16;
      7'd9: t = 15'd17;       7'd10: t = 15'd19;      7'd11: t = 15'd21;
      7'd12: t = 15'd23;      7'd13: t = 15'd25;      7'd14: t = 15'd28;
      7'd15: t = 15'd31;      7'd16: t = 15'd34;      7'd17: t = 15'd37;
      7'd18: t = 15'd41;      7'd19: t = 15'd45;      7'd20: t = 15'd50;
      7'd21: t = 15'd55;      7'd22: t = 15'd60;      7'd23: t = 15'd66;
      7'd24: t = 15'd73;      7'd25: t = 15'd80;      7'd26: t = 15'd88;
      7'd27: t = 15'd97;      7'd28: t = 15'd107;     7'd29: t = 15'd118;
      7'd30: t = 15'd130;     7'd31: t = 15'd143;     7'd32: t = 15'd157;
      7'd33: t = 15'd173;     7'd34: t = 15'd190;     7'd35: t = 15'd209;
      7'd36: t = 15'd230;     7'd37: t = 15'd253;     7'd38: t = 15'd279;
      7'd39: t = 15'd307;     7'd40: t = 15'd337;     7'd41: t = 15'd371;
      7'd42: t = 15'd408;     7'd43: t = 15'd449;     7'd44: t = 15'd494;
      7'd45: t = 15'd544;     7'd46: t = 15'd598;     7'd47: t = 15'd658;
      7'd48: t = 15'd724;     7'd49: t = 15'd796;     7'd50: t = 15'd876;
      7'd51: t = 15'd963;     7'd52: t = 15'd1060;    7'd53: t = 15'd1166;
      7'd54: t = 15'd1282;    7'd55: t = 15'd1411;    7'd56: t = 15'd1552;
      7'd57: t = 15'd1707;    7'd58: t = 15'd1878;    7'd59: t = 15'd2066;
      7'd60: t = 15'd2272;    7'd61: t = 15'd2499;    7'd62: t = 15'd2749;
      7'd63: t = 15'd3024;    7'd64: t = 15'd3327;    7'd65: t = 15'd3660;
      7'd66: t = 15'd4026;    7'd67: t = 15'd4428;    7'd68: t = 15'd4871;
      7'd69: t = 15'd5358;    7'd70: t = 15'd5894;    7'd71: t = 15'd6484;
      7'd72: t = 15'd7132;    7'd73: t = 15'd7845;    7'd74: t = 15'd8630;
      7'd75: t = 15'd9493;    7'd76: t = 15'd10442;   7'd77: t = 15'd11487;
      7'd78: t = 15'd12635;   7'd79: t = 15'd13899;   7'd80: t = 15'd15289;
      7'd81: t = 15'd16818;   7'd82: t = 15'd18500;   7'd83: t = 15'd20350;
      7'd84: t = 15'd22385;   7'd85: t = 15'd24623;   7'd86: t = 15'd27086;
      7'd87: t = 15'd29794;
      default: t = 15'd32767;
    endcase
    return t;
  endfunction

  function automatic logic signed [7:0] index_adj(input logic [2:0] code);
    logic signed [7:0] a;
    case (code)
      3'd4: a = 8'sd2;
      3'd5: a = 8'sd4;
      3'd6: a = 8'sd6;
      3'd7: a = 8'sd8;
      default: a = -8'sd1;
    endcase
    return a;
  endfunction

endpackage

// ----- hdl/adpcm_channel_decoder_core.sv -----
// Top level of the one-channel IMA ADPCM decoder with its context memory.
// Depends on acd_pkg, acd_ram and acd_nibble.
//
//   channel | ports                    | transaction when
//   --------+--------------------------+------------------------------
//   input   | in_valid in_stall in_data   | in_valid high, in_stall low
//   result  | out_valid out_stall out_data| out_valid high, out_stall low
//   config  | cfg_we cfg_index cfg_wdata  | cfg_we high
//
// A new item is not taken while the one before it sits in stage 1: the
// context word is read from the memory when the item is taken and written
// back by stage 2, so the read-modify-write of that one entry sets the pace.
// A result passes stage 1, stage 2 and the result queue before it leaves.
// Reset is synchronous; the memory needs no clearing pass. A stalled result
// channel fills a 4-entry result queue, after which in_stall rises.
module adpcm_channel_decoder_core import acd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration.
  logic [15:0]         loop_start_r;
  logic [21:0]         loop_length_r;
  logic                repeat_r;
  logic [OFFSET_W-1:0] end_off_r;
  logic [22:0]         end_words;
  loop_cfg_t           lcfg;

  // Pipeline.
  logic                in_acc;
  logic                s1_v_r;
  in_item_t            s1_item_r;
  logic                s2_v_r;
  logic                s2_op_r;
  logic [31:0]         s2_word_r;
  logic [3:0]          s2_nib_r;
  logic [15:0]         s2_diff_r;
  ctx_t                s2_ctx_r;
  logic                cap_v_r;
  snap_t               cap_snap_r;

  // Context memory and its read path.
  logic                wr_en;
  logic [RAM_AW-1:0]   wr_addr;
  logic [CTX_W-1:0]    wr_data;
  logic [RAM_AW-1:0]   rd_addr;
  logic [CTX_W-1:0]    ram_q;
  logic [CTX_DEPTH-1:0] vld_r;
  logic                rd_vld_r;
  logic                fwd_hit_r;
  logic [CTX_W-1:0]    fwd_data_r;
  logic [CTX_W-1:0]    rd_eff;
  ctx_t                rd_ctx;
  snap_t               rd_snap;

  // Stage 1 step computation.
  logic [3:0]          s1_nib;
  logic [14:0]         s1_step;
  logic [15:0]         s1_t;
  logic [15:0]         s1_diff;

  // Stage 2 update.
  ctx_t                ctx_nxt;
  logic                capture;
  snap_t               cap_snap;

  // Result queue.
  out_item_t           ofifo_q [OFIFO_DEPTH];
  logic [OFIFO_AW-1:0] ofifo_wp_r;
  logic [OFIFO_AW-1:0] ofifo_rp_r;
  logic [OFIFO_AW:0]   ofifo_cnt_r;
  logic [OFIFO_AW:0]   occupancy;
  logic                push;
  logic                pop;

  // ---------------------------------------------------------------- config
  assign end_words = {7'd0, loop_start_r} + {1'b0, loop_length_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_start_r  <= '0;
      loop_length_r <= '0;
      repeat_r      <= 1'b0;
      end_off_r     <= '0;
    end else begin
      end_off_r <= {end_words, 2'b00};
      if (cfg_we) begin
        case (cfg_index)
          REG_LOOP_START:  loop_start_r  <= cfg_wdata[15:0];
          REG_LOOP_LENGTH: loop_length_r <= cfg_wdata;
          REG_REPEAT:      repeat_r      <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  assign lcfg.start_off   = {7'd0, loop_start_r, 2'b00};
  assign lcfg.end_off     = end_off_r;
  assign lcfg.repeat_loop = repeat_r;

  // ------------------------------------------------------------ flow control
  assign occupancy = ofifo_cnt_r + {{OFIFO_AW{1'b0}}, s2_v_r};
  assign in_stall  = !rst_n || s1_v_r || (occupancy >= (OFIFO_AW+1)'(OFIFO_DEPTH));
  assign in_acc    = in_valid && !in_stall;

  // ---------------------------------------------------------- context memory
  // The context is read while an item is taken, the loop snapshot while it
  // sits in stage 1. Stage 2 writes the context, the cycle after it the
  // snapshot; either write can land on the edge of the matching read.
  assign rd_addr = s1_v_r ? ADDR_SNAP : ADDR_CTX;
  assign wr_en   = s2_v_r || cap_v_r;
  assign wr_addr = s2_v_r ? ADDR_CTX : ADDR_SNAP;
  assign wr_data = s2_v_r ? CTX_W'(ctx_nxt) : {{(CTX_W-SNAP_W){1'b0}}, cap_snap_r};

  acd_ram #(
    .WIDTH (CTX_W),
    .DEPTH (CTX_DEPTH)
  ) u_ctx_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      rd_vld_r  <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      rd_vld_r  <= vld_r[rd_addr];
      fwd_hit_r <= wr_en && (wr_addr == rd_addr);
    end
    fwd_data_r <= wr_data;
  end

  // An entry never written reads as its reset value of zero.
  assign rd_eff  = fwd_hit_r ? fwd_data_r : (rd_vld_r ? ram_q : '0);
  assign rd_ctx  = ctx_t'(rd_eff);
  assign rd_snap = snap_t'(rd_eff[SNAP_W-1:0]);

  // ----------------------------------------------------------------- stage 1
  assign s1_nib  = rd_ctx.second_nibble ? s1_item_r.data_word[7:4]
                                        : s1_item_r.data_word[3:0];
  assign s1_step = step_size(rd_ctx.step_index);
  assign s1_t    = {1'b0, s1_step};
  assign s1_diff = (s1_t >> 3)
                 + (s1_nib[0] ? (s1_t >> 2) : 16'd0)
                 + (s1_nib[1] ? (s1_t >> 1) : 16'd0)
                 + (s1_nib[2] ? s1_t        : 16'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      cap_v_r <= 1'b0;
    end else begin
      s1_v_r  <= in_acc;
      s2_v_r  <= s1_v_r;
      cap_v_r <= s2_v_r && capture;
    end
    if (in_acc) begin
      s1_item_r <= in_data;
    end
    if (s1_v_r) begin
      s2_op_r   <= s1_item_r.opcode;
      s2_word_r <= s1_item_r.data_word;
      s2_nib_r  <= s1_nib;
      s2_diff_r <= s1_diff;
      s2_ctx_r  <= rd_ctx;
    end
    cap_snap_r <= cap_snap;
  end

  // ----------------------------------------------------------------- stage 2
  acd_nibble u_nibble (
    .op       (s2_op_r),
    .word     (s2_word_r),
    .nib      (s2_nib_r),
    .diff     (s2_diff_r),
    .cur      (s2_ctx_r),
    .snap     (rd_snap),
    .lcfg     (lcfg),
    .nxt      (ctx_nxt),
    .capture  (capture),
    .cap_snap (cap_snap)
  );

  // ------------------------------------------------------------ result queue
  assign push = s2_v_r;
  assign pop  = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofifo_wp_r  <= '0;
      ofifo_rp_r  <= '0;
      ofifo_cnt_r <= '0;
    end else begin
      if (push) begin
        ofifo_wp_r <= ofifo_wp_r + OFIFO_AW'(1);
      end
      if (pop) begin
        ofifo_rp_r <= ofifo_rp_r + OFIFO_AW'(1);
      end
      case ({push, pop})
        2'b10:   ofifo_cnt_r <= ofifo_cnt_r + (OFIFO_AW+1)'(1);
        2'b01:   ofifo_cnt_r <= ofifo_cnt_r - (OFIFO_AW+1)'(1);
        default: ofifo_cnt_r <= ofifo_cnt_r;
      endcase
    end
    if (push) begin
      ofifo_q[ofifo_wp_r] <= '{sample_out:       ctx_nxt.sample_value,
                               byte_offset_out:  ctx_nxt.byte_offset,
                               high_nibble_next: ctx_nxt.second_nibble,
                               playing:          ctx_nxt.active};
    end
  end

  assign out_valid = (ofifo_cnt_r != '0);
  assign out_data  = ofifo_q[ofifo_rp_r];

endmodule

// ----- hdl/acd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module acd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hdl/acd_nibble.sv -----
// Context update for one transaction: header load or one nibble decode,
// saturation, index clamp, loop capture and loop end. Depends on acd_pkg.
module acd_nibble import acd_pkg::*; (
  input  logic        op,
  input  logic [31:0] word,
  input  logic [3:0]  nib,
  input  logic [15:0] diff,
  input  ctx_t        cur,
  input  snap_t       snap,
  input  loop_cfg_t   lcfg,
  output ctx_t        nxt,
  output logic        capture,
  output snap_t       cap_snap
);

  localparam logic signed [17:0] SAT_MAX = 18'(SAMPLE_MAX);
  localparam logic signed [17:0] SAT_MIN = 18'(SAMPLE_MIN);

  logic signed [17:0] s_ext;
  logic signed [17:0] add_res;
  logic signed [17:0] sub_res;
  logic signed [15:0] new_sample;
  logic signed [7:0]  idx_sum;
  logic [6:0]         new_index;
  logic [6:0]         hdr_index;
  logic [OFFSET_W-1:0] inc_off;

  assign s_ext   = 18'(cur.sample_value);
  assign add_res = s_ext + $signed({2'b00, diff});
  assign sub_res = s_ext - $signed({2'b00, diff});
  assign idx_sum = $signed({1'b0, cur.step_index}) + index_adj(nib[2:0]);
  assign hdr_index = word[22:16];
  assign inc_off = cur.byte_offset + OFFSET_W'(1);

  always_comb begin
    if (nib[3]) begin
      new_sample = (sub_res < SAT_MIN) ? SAMPLE_MIN : sub_res[15:0];
    end else begin
      new_sample = (add_res > SAT_MAX) ? SAMPLE_MAX : add_res[15:0];
    end
    if (idx_sum < 8'sd0) begin
      new_index = 7'd0;
    end else if (idx_sum > $signed({1'b0, INDEX_MAX})) begin
      new_index = INDEX_MAX;
    end else begin
      new_index = idx_sum[6:0];
    end
  end

  always_comb begin
    nxt      = cur;
    capture  = 1'b0;
    cap_snap = snap;
    if (op == OP_START) begin
      nxt.sample_value  = word[15:0];
      nxt.step_index    = (hdr_index > INDEX_MAX) ? INDEX_MAX : hdr_index;
      nxt.second_nibble = 1'b0;
      nxt.byte_offset   = OFFSET_W'(4);
      nxt.active        = 1'b1;
    end else if (cur.active) begin
      nxt.sample_value  = new_sample;
      nxt.step_index    = new_index;
      nxt.second_nibble = ~cur.second_nibble;
      // A finished high nibble moves to the next byte and may hit the loop start.
      if (cur.second_nibble) begin
        nxt.byte_offset = inc_off;
        if (inc_off == lcfg.start_off) begin
          capture              = 1'b1;
          cap_snap.loop_sample = new_sample;
          cap_snap.loop_index  = new_index;
        end
      end
      if (nxt.byte_offset == lcfg.end_off) begin
        if (lcfg.repeat_loop) begin
          nxt.byte_offset   = lcfg.start_off;
          nxt.sample_value  = cap_snap.loop_sample;
          nxt.step_index    = cap_snap.loop_index;
          nxt.second_nibble = 1'b0;
        end else begin
          nxt.active = 1'b0;
        end
      end
    end
  end

endmodule

// ----- hdl/acd_chk.sv -----
// Port-level checker for the ADPCM channel decoder, bound to the top level.
// Depends on acd_pkg and adpcm_channel_decoder_core_macros.svh.
`include "adpcm_channel_decoder_core_macros.svh"

module acd_chk import acd_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A stalled result stays on the port unchanged.
  `ACD_ASSERT_DEF(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "result moved")

  // The context round trip keeps the input stalled after each accepted transaction.
  `ACD_ASSERT_DEF(a_in_spacing, in_valid && !in_stall |=> in_stall, "input taken twice in a row")

  // A result appearing on an empty queue traces back to an accepted input transaction.
  `ACD_ASSERT_DEF(a_out_origin, $rose(out_valid) |-> $past(in_valid && !in_stall, 3), "no input")

endmodule

bind adpcm_channel_decoder_core acd_chk u_acd_chk (.*);

// ----- tb/tb_adpcm_channel_decoder_core.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for adpcm_channel_decoder_core: a predictor tracks one
// channel's decode state and checks every result in order. Depends on acd_pkg.

import acd_pkg::*;

class sample_scoreboard;
  int step_tab[89];

  logic [15:0]         loop_start_w;
  logic [21:0]         loop_len_w;
  logic                rep;

  logic signed [15:0]  sample;
  logic [6:0]          index;
  logic                high_next;
  logic [OFFSET_W-1:0] offset;
  logic signed [15:0]  loop_sample;
  logic [6:0]          loop_index;
  logic                playing;

  out_item_t pending_results[$];
  int        mismatches;

  function new();
    step_tab = '{
      7, 8, 9, 10, 11, 12, 13, 14, 16, 17, 19, 21, 23, 25, 28, 31,
      34, 37, 41, 45, 50, 55, 60, 66, 73, 80, 88, 97, 107, 118, 130, 143,
      157, 173, 190, 209, 230, 253, 279, 307, 337, 371, 408, 449, 494, 544, 598, 658,
      724, 796, 876, 963, 1060, 1166, 1282, 1411, 1552, 1707, 1878, 2066, 2272, 2499,
      2749, 3024, 3327, 3660, 4026, 4428, 4871, 5358, 5894, 6484, 7132, 7845, 8630,
      9493, 10442, 11487, 12635, 13899, 15289, 16818, 18500, 20350, 22385, 24623,
      27086, 29794, 32767};
    loop_start_w = '0;
    loop_len_w   = '0;
    rep          = 1'b0;
    sample       = '0;
    index        = '0;
    high_next    = 1'b0;
    offset       = '0;
    loop_sample  = '0;
    loop_index   = '0;
    playing      = 1'b0;
    mismatches   = 0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_LOOP_START:  loop_start_w = val[15:0];
      REG_LOOP_LENGTH: loop_len_w   = val[21:0];
      REG_REPEAT:      rep          = val[0];
      default: ;
    endcase
  endfunction

  // Advances the channel by one accepted input transaction and queues the result.
  function void note_item(in_item_t it);
    logic [3:0]          nib;
    int                  t;
    int                  diff;
    int                  s;
    int                  ni;
    logic [OFFSET_W-1:0] start_off;
    logic [OFFSET_W-1:0] end_off;
    out_item_t           exp;
    start_off = OFFSET_W'(32'(loop_start_w) * 4);
    end_off   = OFFSET_W'((32'(loop_start_w) + 32'(loop_len_w)) * 4);
    if (it.opcode == OP_START) begin
      sample    = it.data_word[15:0];
      index     = (it.data_word[22:16] > INDEX_MAX) ? INDEX_MAX : it.data_word[22:16];
      high_next = 1'b0;
      offset    = OFFSET_W'(4);
      playing   = 1'b1;
    end else if (playing) begin
      nib  = high_next ? it.data_word[7:4] : it.data_word[3:0];
      t    = step_tab[index];
      diff = t / 8;
      if (nib[0]) diff += t / 4;
      if (nib[1]) diff += t / 2;
      if (nib[2]) diff += t;
      // Saturation only applies in the direction of the update.
      if (nib[3]) begin
        s = int'(sample) - diff;
        if (s < -32767) s = -32767;
      end else begin
        s = int'(sample) + diff;
        if (s > 32767) s = 32767;
      end
      sample = 16'(s);
      ni = int'(index) + (nib[2] ? 2 * (int'(nib[1:0]) + 1) : -1);
      if (ni < 0) ni = 0;
      if (ni > 88) ni = 88;
      index     = 7'(ni);
      high_next = ~high_next;
      if (!high_next) begin
        offset = offset + 1'b1;
        if (offset == start_off) begin
          loop_sample = sample;
          loop_index  = index;
        end
      end
      if (offset == end_off) begin
        if (rep) begin
          offset    = start_off;
          sample    = loop_sample;
          index     = loop_index;
          high_next = 1'b0;
        end else begin
          playing = 1'b0;
        end
      end
    end
    exp.sample_out       = sample;
    exp.byte_offset_out  = offset;
    exp.high_nibble_next = high_next;
    exp.playing          = playing;
    pending_results.push_back(exp);
  endfunction

  function void check_result(out_item_t got);
    out_item_t exp;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result transaction: sample %0d offset %0d high %0b play %0b",
                 got.sample_out, got.byte_offset_out, got.high_nibble_next, got.playing);
      return;
    end
    exp = pending_results.pop_front();
    if (got.sample_out !== exp.sample_out || got.byte_offset_out !== exp.byte_offset_out ||
        got.high_nibble_next !== exp.high_nibble_next || got.playing !== exp.playing) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch at %0t: expected %0d %0d %0b %0b, got %0d %0d %0b %0b",
                 $realtime, exp.sample_out, exp.byte_offset_out, exp.high_nibble_next,
                 exp.playing, got.sample_out, got.byte_offset_out, got.high_nibble_next,
                 got.playing);
    end
  endfunction
endclass

module tb_adpcm_channel_decoder_core;
  localparam int PHASES         = 12;
  localparam int PHASE_ITEMS    = 132;
  localparam int SQUEEZE_CYCLES = 60;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_item_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sample_scoreboard board;
  bit quiet;
  bit squeeze_req;

  adpcm_channel_decoder_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic in_item_t as_item(logic op, logic [31:0] word);
    in_item_t it;
    it.opcode    = op;
    it.data_word = word;
    return it;
  endfunction

  task automatic send_item(input in_item_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_item(it);
  endtask

  // Waits for every expected result, then lets the pipeline settle.
  task automatic drain();
    while (board.pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_loop_regs(input logic [15:0] ls, input logic [21:0] ll,
                                 input logic rep);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LOOP_START;
    cfg_wdata <= CFG_DATA_W'(ls);
    @(posedge clk);
    board.set_reg(REG_LOOP_START, CFG_DATA_W'(ls));
    cfg_index <= REG_LOOP_LENGTH;
    cfg_wdata <= ll;
    @(posedge clk);
    board.set_reg(REG_LOOP_LENGTH, ll);
    cfg_index <= REG_REPEAT;
    cfg_wdata <= CFG_DATA_W'(rep);
    @(posedge clk);
    board.set_reg(REG_REPEAT, CFG_DATA_W'(rep));
    cfg_we <= 1'b0;
  endtask

  // Result side: random stall bursts, plus one long hold-off when requested.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        out_stall <= 1'b1;
        repeat (SQUEEZE_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (!quiet && rst_n && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
  end

  initial begin
    #1_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int          played;
    bit          squeezed;
    logic [15:0] ls;
    logic [21:0] ll;
    logic        rep;
    logic [31:0] header;
    board       = new();
    quiet       = 1'b0;
    squeeze_req = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= REG_LOOP_START;
    cfg_wdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: one-word loop that starts at the header, so it is never captured.
    write_loop_regs(16'd1, 22'd1, 1'b1);
    send_item(as_item(OP_STEP, 32'hFFFF_FFFF));     // step while stopped
    send_item(as_item(OP_START, 32'hFFFF_7FFF));    // max sample, index capped
    send_item(as_item(OP_STEP, 32'hFFFF_FF77));     // positive saturation
    send_item(as_item(OP_STEP, 32'h0000_0077));
    send_item(as_item(OP_START, 32'h0000_8000));    // most negative sample
    send_item(as_item(OP_STEP, 32'h0000_0008));     // clamp up to -0x7fff
    send_item(as_item(OP_STEP, 32'h0000_0080));
    send_item(as_item(OP_START, 32'h0058_0000));    // top index, restart while playing
    send_item(as_item(OP_STEP, 32'h0000_00FF));     // negative saturation
    send_item(as_item(OP_START, 32'h0034_0000));
    repeat (8) send_item(as_item(OP_STEP, $urandom));
    in_valid <= 1'b0;

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: begin ls = 16'd2;    ll = 22'd1;        rep = 1'b1; end
        1: begin ls = 16'd3;    ll = 22'd2;        rep = 1'b1; end
        2: begin ls = 16'd2;    ll = 22'd3;        rep = 1'b0; end
        3: begin ls = 16'd0;    ll = 22'd2;        rep = 1'b1; end
        4: begin ls = 16'd1;    ll = 22'd0;        rep = 1'b1; end
        5: begin ls = 16'd1;    ll = 22'd0;        rep = 1'b0; end
        6: begin ls = 16'hFFFF; ll = 22'h3F_FFFF; rep = 1'b1; end
        7: begin ls = 16'd0;    ll = 22'd0;        rep = 1'b0; end
        default: begin
          ls  = 16'($urandom_range(0, 4));
          ll  = 22'($urandom_range(0, 6));
          rep = 1'($urandom_range(0, 1));
        end
      endcase
      write_loop_regs(ls, ll, rep);
      quiet    = (ph == PHASES - 1);
      played   = 0;
      squeezed = 1'b0;
      while (played < PHASE_ITEMS) begin
        // Long result hold-off while input keeps coming, to back up the block.
        if ((ph == 1 || ph == 8) && played >= 30 && !squeezed) begin
          squeeze_req = 1'b1;
          squeezed    = 1'b1;
        end
        if ($urandom_range(0, 9) == 0) begin
          send_item(as_item(1'($urandom_range(0, 1)), $urandom));
          played++;
        end else begin
          header = $urandom;
          if ($urandom_range(0, 1) == 1) header[22:16] = 7'($urandom_range(0, 30));
          send_item(as_item(OP_START, header));
          played++;
          repeat ($urandom_range(1, 40)) begin
            if (played < PHASE_ITEMS) begin
              send_item(as_item(OP_STEP, $urandom));
              played++;
            end
          end
        end
      end
      in_valid <= 1'b0;
    end

    drain();
    repeat (10) @(posedge clk);
    if (board.mismatches == 0 && board.pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
